>>> hdl/mae_pkg.sv
package mae_pkg;

    localparam int WordBits = 32;
    localparam int RegIdxBits = 5;
    localparam int RegCount = 32;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    // request to the multiply/divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        sgn;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;

endpackage

>>> hdl/mae_regfile.sv
module mae_regfile
    import mae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [RegIdxBits-1:0] rd_a_idx,
    input  logic [RegIdxBits-1:0] rd_b_idx,
    output logic [WordBits-1:0]   rd_a_data,
    output logic [WordBits-1:0]   rd_b_data,
    input  logic                  wr_en,
    input  logic [RegIdxBits-1:0] wr_idx,
    input  logic [WordBits-1:0]   wr_data
);

    logic [WordBits-1:0] mem [RegCount];
    logic [RegCount-1:0] valid_reg;
    logic [WordBits-1:0] a_raw_reg;
    logic [WordBits-1:0] b_raw_reg;
    logic                a_ok_reg;
    logic                b_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        a_raw_reg <= mem[rd_a_idx];
        b_raw_reg <= mem[rd_b_idx];
    end

    // entries never written and r0 read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            a_ok_reg  <= 1'b0;
            b_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            a_ok_reg <= valid_reg[rd_a_idx] && (rd_a_idx != '0);
            b_ok_reg <= valid_reg[rd_b_idx] && (rd_b_idx != '0);
        end
    end

    assign rd_a_data = a_ok_reg ? a_raw_reg : '0;
    assign rd_b_data = b_ok_reg ? b_raw_reg : '0;

endmodule

>>> hdl/mae_muldiv.sv
module mae_muldiv
    import mae_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    // one bit per cycle: shift-add multiply, restoring divide, on magnitudes
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        div_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [31:0] mb_reg;
    logic [63:0] acc_reg;
    logic [32:0] rem_reg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic        na;
    logic        nb;
    logic [32:0] add_sum;
    logic [32:0] trial;
    logic [63:0] prod_fix;
    logic [31:0] q_fix;
    logic [31:0] r_fix;

    assign na = req.sgn && req.a[31];
    assign nb = req.sgn && req.b[31];
    assign ma = na ? (~req.a + 32'd1) : req.a;
    assign mb = nb ? (~req.b + 32'd1) : req.b;
    assign add_sum = (acc_reg[0] ? {1'b0, mb_reg} : 33'd0) + {1'b0, acc_reg[63:32]};
    assign trial = {rem_reg[31:0], acc_reg[31]} - {1'b0, mb_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg   <= req.is_div;
            neg_q_reg <= na ^ nb;
            neg_r_reg <= na;
            mb_reg    <= mb;
            acc_reg   <= {32'd0, ma};
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (!div_reg)
            begin
                acc_reg <= {add_sum, acc_reg[31:1]};
            end
            else if (!trial[32])
            begin
                rem_reg <= trial;
                acc_reg <= {32'd0, acc_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], acc_reg[31]};
                acc_reg <= {32'd0, acc_reg[30:0], 1'b0};
            end
        end
    end

    assign prod_fix = neg_q_reg ? (~acc_reg + 64'd1) : acc_reg;
    assign q_fix = neg_q_reg ? (~acc_reg[31:0] + 32'd1) : acc_reg[31:0];
    assign r_fix = neg_r_reg ? (~rem_reg[31:0] + 32'd1) : rem_reg[31:0];

    // the sequencer counts the cycles; results hold once idle
    assign rsp.hi = div_reg ? r_fix : prod_fix[63:32];
    assign rsp.lo = div_reg ? q_fix : prod_fix[31:0];

endmodule

>>> hdl/mips_integer_alu_execute_core.sv
// MIPS I integer execute block with its own register file and HI/LO.
// Input channel: instruction_word with instruction_valid/instruction_ready.
// Output channel: reg_written, dest_index, dest_value, overflow_trap,
// hi_value, lo_value and unknown_op with result_valid/result_ready.
// One instruction is in flight at a time. An ALU instruction passes
// from acceptance through register file read (synchronous memory),
// execute, write back and output. MULT/MULTU/DIV/DIVU also wait in
// ST_MUL for the one-bit-per-cycle multiply/divide unit and then
// update HI/LO in ST_DIV. The next word can be taken in the cycle after
// the result is accepted, so a new instruction never overlaps the last.
// The register file sits in a synchronous RAM; per-entry valid bits make
// every register read as zero after reset, so no clearing pass is needed.
// Reset clears HI, LO and the sequencer; the block is ready at once.
// While the receiver stalls the result word is held in the output
// register and no new instruction is taken.
module mips_integer_alu_execute_core
    import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        instruction_valid,
    output logic        instruction_ready,
    input  logic [31:0] instruction_word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        overflow_trap,
    output logic [31:0] hi_value,
    output logic [31:0] lo_value,
    output logic        unknown_op
);

    state_t      state_reg, state_next;
    logic [31:0] ir_reg;
    logic [5:0]  md_cnt_reg, md_cnt_next;
    logic [31:0] hi_reg, lo_reg;
    logic [31:0] a, b;
    md_req_t     md_req;
    md_rsp_t     md_rsp;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] immz, imms;

    logic        wr_reg, ovf_reg, unk_reg;
    logic [4:0]  dst_reg;
    logic [31:0] res_reg;
    logic        e_wr, e_ovf, e_unk, e_md, e_div, e_sgn;
    logic [4:0]  e_dst, e_sa;
    logic [31:0] e_res, e_sum, e_dif, e_addi;
    logic        hilo_we;
    logic [31:0] hi_in, lo_in;

    assign op   = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sh   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign immz = {16'd0, ir_reg[15:0]};
    assign imms = {{16{ir_reg[15]}}, ir_reg[15:0]};

    mae_regfile u_rf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_idx  (rs),
        .rd_b_idx  (rt),
        .rd_a_data (a),
        .rd_b_data (b),
        .wr_en     (state_reg == ST_FIN && wr_reg),
        .wr_idx    (dst_reg),
        .wr_data   (res_reg)
    );

    assign md_req.start  = (state_reg == ST_EXEC) && e_md;
    assign md_req.is_div = e_div;
    assign md_req.sgn    = e_sgn;
    assign md_req.a      = a;
    assign md_req.b      = b;

    mae_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign e_sum  = a + b;
    assign e_dif  = a - b;
    assign e_addi = a + imms;
    assign e_sa   = (fn == FN_SLLV || fn == FN_SRLV || fn == FN_SRAV) ? a[4:0] : sh;

    always_comb
    begin
        e_wr  = 1'b1;
        e_ovf = 1'b0;
        e_unk = 1'b0;
        e_md  = 1'b0;
        e_div = 1'b0;
        e_sgn = 1'b0;
        e_res = '0;
        e_dst = (op == OP_SPECIAL) ? rd : rt;
        if (op == OP_SPECIAL)
        begin
            unique case (fn)
                FN_SLL, FN_SLLV: e_res = b << e_sa;
                FN_SRL, FN_SRLV: e_res = b >> e_sa;
                FN_SRA, FN_SRAV: e_res = $unsigned($signed(b) >>> e_sa);
                FN_MULT:  begin e_md = 1'b1; e_sgn = 1'b1; end
                FN_MULTU: e_md = 1'b1;
                FN_DIV:   begin e_md = 1'b1; e_div = 1'b1; e_sgn = 1'b1; e_wr = 1'b0; end
                FN_DIVU:  begin e_md = 1'b1; e_div = 1'b1; e_wr = 1'b0; end
                FN_ADD:
                begin
                    e_res = e_sum;
                    e_ovf = (a[31] ^ e_sum[31]) & (b[31] ^ e_sum[31]);
                end
                FN_ADDU: e_res = e_sum;
                FN_SUB:
                begin
                    e_res = e_dif;
                    e_ovf = (a[31] ^ b[31]) & (a[31] ^ e_dif[31]);
                end
                FN_SUBU: e_res = e_dif;
                FN_AND:  e_res = a & b;
                FN_OR:   e_res = a | b;
                FN_XOR:  e_res = a ^ b;
                FN_NOR:  e_res = ~(a | b);
                FN_SLT:  e_res = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU: e_res = {31'd0, a < b};
                default: begin e_wr = 1'b0; e_unk = 1'b1; end
            endcase
        end
        else
        begin
            unique case (op)
                OP_ADDI:
                begin
                    e_res = e_addi;
                    e_ovf = (a[31] ^ e_addi[31]) & (imms[31] ^ e_addi[31]);
                end
                OP_ADDIU: e_res = e_addi;
                OP_SLTI:  e_res = {31'd0, $signed(a) < $signed(imms)};
                OP_SLTIU: e_res = {31'd0, a < imms};
                OP_ANDI:  e_res = a & immz;
                OP_ORI:   e_res = a | immz;
                OP_XORI:  e_res = a ^ immz;
                default:  begin e_wr = 1'b0; e_unk = 1'b1; end
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        md_cnt_next = md_cnt_reg;
        unique case (state_reg)
            ST_IDLE: if (instruction_valid) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (e_md)
                begin
                    state_next  = ST_MUL;
                    md_cnt_next = 6'd32;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL:
            begin
                md_cnt_next = md_cnt_reg - 6'd1;
                if (md_cnt_reg == 6'd0)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: state_next = ST_FIN;
            ST_FIN: state_next = ST_OUT;
            ST_OUT: if (result_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign instruction_ready = (state_reg == ST_IDLE);
    assign result_valid      = (state_reg == ST_OUT);

    // HI/LO update once the unit has finished; divide by zero keeps them
    always_comb
    begin
        hilo_we = 1'b0;
        hi_in   = md_rsp.hi;
        lo_in   = md_rsp.lo;
        if (state_reg == ST_DIV)
        begin
            if (e_div)
            begin
                if (e_sgn && a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                begin
                    hilo_we = 1'b1;
                    hi_in   = '0;
                    lo_in   = 32'h8000_0000;
                end
                else
                begin
                    hilo_we = (b != '0);
                end
            end
            else
            begin
                hilo_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            md_cnt_reg <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
            wr_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            md_cnt_reg <= md_cnt_next;
            if (hilo_we)
            begin
                hi_reg <= hi_in;
                lo_reg <= lo_in;
            end
            if (state_reg == ST_EXEC)
            begin
                wr_reg <= e_wr && !e_ovf && (e_dst != '0);
            end
            else if (state_reg == ST_DIV && !e_div)
            begin
                wr_reg <= (e_dst != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instruction_valid && instruction_ready)
        begin
            ir_reg <= instruction_word;
        end
        if (state_reg == ST_EXEC)
        begin
            ovf_reg <= e_ovf;
            unk_reg <= e_unk;
            dst_reg <= e_dst;
            res_reg <= e_res;
        end
        else if (state_reg == ST_DIV && !e_div)
        begin
            res_reg <= md_rsp.lo;
        end
    end

    assign reg_written   = wr_reg;
    assign dest_index    = wr_reg ? dst_reg : '0;
    assign dest_value    = wr_reg ? res_reg : '0;
    assign overflow_trap = ovf_reg;
    assign hi_value      = hi_reg;
    assign lo_value      = lo_reg;
    assign unknown_op    = unk_reg;

endmodule
